/* src/grs_pkg.sv */
package grs_pkg;

    localparam int MAX_SIDE = 16;
    localparam int SIDE     = MAX_SIDE + 2;
    localparam int CELLS    = SIDE * SIDE * SIDE;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = 31;
    localparam int ACC_W    = VAL_W + 3;
    localparam int MAG_W    = VAL_W + 19;
    localparam int DIV_NW   = VAL_W + 1 + FRAC_W;
    localparam int DIV_DW   = 31;
    localparam int SWEEPS   = 10;
    localparam int CFG_IW   = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] MAG_VMAX = {{(MAG_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic [MAG_W-1:0] MAG_VMIN = {{(MAG_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [DIV_DW-1:0] DIV_ONE = DIV_DW'(1 << FRAC_W);

    localparam logic [CFG_IW-1:0] CFG_SIZE_X   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BMODE    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_GAIN     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_DIVISOR  = 3'd5;

    localparam logic [1:0] BMODE_NEG_X = 2'd1;
    localparam logic [1:0] BMODE_NEG_Y = 2'd2;
    localparam logic [1:0] BMODE_NEG_Z = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SOLVE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    typedef enum logic [2:0] {
        NB_XM, NB_XP, NB_YM, NB_YP, NB_ZM, NB_ZP
    } t_nbr;

    typedef enum logic [1:0] {
        WS_DIV,
        WS_FACE,
        WS_EDGE
    } t_wsel;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT,
        S_U_START, S_U_RD, S_U_SUM, S_U_MUL, S_U_TERM, S_U_NUM, S_U_DGO, S_U_DWAIT, S_U_WR,
        S_B_SCAN, S_B_RD, S_B_SUM, S_B_CALC, S_B_DWAIT, S_B_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             host_wr;
        logic             host_rd;
        logic             flag_clr;
        logic             rd_sol;
        logic             rd_src;
        logic             acc_clr;
        logic             mul;
        logic             term;
        logic             num;
        logic             div_upd;
        logic             div_corner;
        logic             wr;
        t_wsel            wsel;
        logic [2:0]       mask;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [POS_W-1:0] cz;
        logic             out_read;
        logic             out_solve;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0] size_m;
        logic [POS_W-1:0] size_n;
        logic [POS_W-1:0] size_o;
        logic             div_busy;
    } t_stat;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             ovf;
    } t_sat;

    function automatic t_sat sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        t_sat r;
        logic [MAG_W-1:0] nmag;
        nmag = ~mag + MAG_W'(1);
        if (!neg) begin
            if (mag > MAG_VMAX) begin
                r.value = VAL_MAX;
                r.ovf   = 1'b1;
            end else begin
                r.value = mag[VAL_W-1:0];
                r.ovf   = 1'b0;
            end
        end else begin
            if (mag > MAG_VMIN) begin
                r.value = VAL_MIN;
                r.ovf   = 1'b1;
            end else begin
                r.value = nmag[VAL_W-1:0];
                r.ovf   = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] i,
                                                    input logic [POS_W-1:0] j,
                                                    input logic [POS_W-1:0] k);
        return ADDR_W'(32'(i) + 32'(j) * SIDE + 32'(k) * (SIDE * SIDE));
    endfunction

    function automatic logic [POS_W-1:0] clamp_size(input logic [POS_W-1:0] s);
        logic [POS_W-1:0] r;
        if (s == '0) begin
            r = POS_W'(1);
        end else if (32'(s) > MAX_SIDE) begin
            r = POS_W'(MAX_SIDE);
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

/* src/grs_divider.sv */
module grs_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [grs_pkg::DIV_NW-1:0] i_num,
    input  logic [grs_pkg::DIV_DW-1:0] i_den,
    output logic                       o_busy,
    output logic [grs_pkg::DIV_NW-1:0] o_quot
);
    import grs_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_n;
    logic [DIV_DW-1:0] r_d;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW:0]   trial;
    logic              ge;

    // restoring division, one quotient bit a cycle shifted into the numerator register
    assign trial = {r_rem, r_n[DIV_NW-1]};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_d   <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? DIV_DW'(trial - {1'b0, r_d}) : trial[DIV_DW-1:0];
            r_n   <= {r_n[DIV_NW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_n;

endmodule

/* src/grs_datapath.sv */
module grs_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  grs_pkg::t_cmd              i_cmd,
    output grs_pkg::t_stat             o_stat,
    input  logic [grs_pkg::POS_W-1:0]  i_pos_i,
    input  logic [grs_pkg::POS_W-1:0]  i_pos_j,
    input  logic [grs_pkg::POS_W-1:0]  i_pos_k,
    input  logic signed [31:0]         i_source_value,
    input  logic signed [31:0]         i_guess_value,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [grs_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [30:0]                i_cfg_data,
    output logic                       o_result_valid,
    output logic                       o_result_kind,
    output logic signed [31:0]         o_cell_value,
    output logic                       o_saturated
);
    import grs_pkg::*;

    logic [POS_W-1:0]  r_size_x, r_size_y, r_size_z;
    logic [1:0]        r_bmode;
    logic [GAIN_W-1:0] r_gain;
    logic [DIV_DW-1:0] r_cdiv;

    logic [VAL_W-1:0]  r_sol_mem [CELLS];
    logic [VAL_W-1:0]  r_src_mem [CELLS];
    logic signed [VAL_W-1:0] r_sol_rd, r_src_rd;
    logic              r_pend;
    logic              r_rd_inside;

    logic signed [ACC_W-1:0] r_acc;
    logic [62:0]       r_p0;
    logic [33:0]       r_p1;
    logic              r_sign;
    logic signed [VAL_W-1:0] r_term;
    logic [VAL_W:0]    r_a;
    logic              r_neg;
    logic              r_dneg;
    logic              r_flag;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_sat;

    logic              host_inside;
    logic [ADDR_W-1:0] host_addr, core_addr, raddr, waddr;
    logic              sol_we;
    logic [VAL_W-1:0]  sol_wdata;
    logic [ACC_W-1:0]  acc_mag;
    logic [MAG_W-1:0]  tm;
    t_sat              term_sat, div_sat, face_sat, edge_sat, wr_sat;
    logic signed [VAL_W+1:0] num;
    logic [VAL_W+1:0]  num_neg;
    logic [DIV_DW-1:0] eff_div;
    logic              div_start;
    logic [DIV_NW-1:0] div_num, quot;
    logic [DIV_DW-1:0] div_den;
    logic              div_busy;
    logic              face_negate;
    logic [ACC_W-1:0]  edge_mag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= POS_W'(MAX_SIDE);
            r_size_y <= POS_W'(MAX_SIDE);
            r_size_z <= POS_W'(MAX_SIDE);
            r_bmode  <= '0;
            r_gain   <= GAIN_W'(1 << FRAC_W);
            r_cdiv   <= DIV_DW'(6 << FRAC_W);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SIZE_X:  r_size_x <= i_cfg_data[POS_W-1:0];
                CFG_SIZE_Y:  r_size_y <= i_cfg_data[POS_W-1:0];
                CFG_SIZE_Z:  r_size_z <= i_cfg_data[POS_W-1:0];
                CFG_BMODE:   r_bmode  <= i_cfg_data[1:0];
                CFG_GAIN:    r_gain   <= i_cfg_data;
                CFG_DIVISOR: r_cdiv   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stat.size_m   = clamp_size(r_size_x);
    assign o_stat.size_n   = clamp_size(r_size_y);
    assign o_stat.size_o   = clamp_size(r_size_z);
    assign o_stat.div_busy = div_busy;

    // cell memories
    assign host_inside = (32'(i_pos_i) < SIDE) && (32'(i_pos_j) < SIDE) && (32'(i_pos_k) < SIDE);
    assign host_addr   = cell_addr(i_pos_i, i_pos_j, i_pos_k);
    assign core_addr   = cell_addr(i_cmd.cx, i_cmd.cy, i_cmd.cz);
    assign raddr       = i_cmd.host_rd ? host_addr : core_addr;
    assign waddr       = i_cmd.host_wr ? host_addr : core_addr;
    assign sol_we      = (i_cmd.host_wr && host_inside) || i_cmd.wr;
    assign sol_wdata   = i_cmd.host_wr ? i_guess_value : wr_sat.value;

    always_ff @(posedge i_clk) begin
        if (sol_we) begin
            r_sol_mem[waddr] <= sol_wdata;
        end
        if (i_cmd.host_rd || i_cmd.rd_sol) begin
            r_sol_rd <= r_sol_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.host_wr && host_inside) begin
            r_src_mem[host_addr] <= i_source_value;
        end
        if (i_cmd.rd_src) begin
            r_src_rd <= r_src_mem[core_addr];
        end
    end

    // neighbor sum, gain product and numerator
    assign acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign tm      = {1'b0, r_p1, {FRAC_W{1'b0}}}
                   + MAG_W'((r_p0 + 63'h8000) >> FRAC_W);
    assign term_sat = sat_mag(r_sign, tm);
    assign num      = (VAL_W+2)'(r_src_rd) + (VAL_W+2)'(r_term);
    assign num_neg  = -num;
    assign eff_div  = (r_cdiv < DIV_ONE) ? DIV_ONE : r_cdiv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_pend) begin
            r_acc <= r_acc + ACC_W'(r_sol_rd);
        end
        if (i_cmd.mul) begin
            r_p0   <= 63'(r_gain) * 63'(acc_mag[31:0]);
            r_p1   <= 34'(r_gain) * 34'(acc_mag[ACC_W-1:32]);
            r_sign <= r_acc[ACC_W-1];
        end
        if (i_cmd.term) begin
            r_term <= term_sat.value;
        end
        if (i_cmd.num) begin
            r_neg <= num[VAL_W+1];
            r_a   <= num[VAL_W+1] ? num_neg[VAL_W:0] : num[VAL_W:0];
        end
        if (div_start) begin
            r_dneg <= i_cmd.div_upd ? r_neg : r_acc[ACC_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_sol;
        end
    end

    // shared serial divider: cell update, and thirds for corners
    assign div_start = i_cmd.div_upd || i_cmd.div_corner;
    assign div_num   = i_cmd.div_upd ? ({r_a, {FRAC_W{1'b0}}} + DIV_NW'(eff_div >> 1))
                                     : (DIV_NW'(acc_mag) + DIV_NW'(1));
    assign div_den   = i_cmd.div_upd ? eff_div : DIV_DW'(3);

    grs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // boundary values
    always_comb begin
        case (r_bmode)
            BMODE_NEG_X: face_negate = i_cmd.mask[0];
            BMODE_NEG_Y: face_negate = i_cmd.mask[1];
            BMODE_NEG_Z: face_negate = i_cmd.mask[2];
            default:     face_negate = 1'b0;
        endcase
    end

    assign edge_mag = (acc_mag + ACC_W'(1)) >> 1;
    assign div_sat  = sat_mag(r_dneg, MAG_W'(quot));
    assign face_sat = sat_mag(r_acc[ACC_W-1] ^ face_negate, MAG_W'(acc_mag));
    assign edge_sat = sat_mag(r_acc[ACC_W-1], MAG_W'(edge_mag));

    always_comb begin
        case (i_cmd.wsel)
            WS_FACE: wr_sat = face_sat;
            WS_EDGE: wr_sat = edge_sat;
            default: wr_sat = div_sat;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_cmd.flag_clr) begin
            r_flag <= 1'b0;
        end else if ((i_cmd.term && term_sat.ovf) || (i_cmd.wr && wr_sat.ovf)) begin
            r_flag <= 1'b1;
        end
    end

    // results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.out_read || i_cmd.out_solve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.host_rd) begin
            r_rd_inside <= host_inside;
        end
        if (i_cmd.out_read || i_cmd.out_solve) begin
            r_out_kind  <= i_cmd.out_read;
            r_out_value <= (i_cmd.out_read && r_rd_inside) ? r_sol_rd : '0;
            r_out_sat   <= r_flag;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_cell_value   = r_out_value;
    assign o_saturated    = r_out_sat;

endmodule

/* src/grs_ctrl.sv */
module grs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_operation,
    input  grs_pkg::t_stat i_stat,
    output grs_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import grs_pkg::*;

    t_state           r_state, n_state;
    logic [3:0]       r_sweep, n_sweep;
    logic [POS_W-1:0] r_ci, n_ci, r_cj, n_cj, r_ck, n_ck;
    t_nbr             r_t, n_t;
    t_axis            r_ax, n_ax;
    logic [1:0]       r_phase, n_phase;

    logic [POS_W-1:0] m, n, o, m1, n1, o1;
    logic [2:0]       mask;
    logic [1:0]       bcount;
    t_state           adv_state;
    logic [3:0]       adv_sweep;
    logic [POS_W-1:0] adv_ci, adv_cj, adv_ck;
    logic [1:0]       adv_phase;

    assign m  = i_stat.size_m;
    assign n  = i_stat.size_n;
    assign o  = i_stat.size_o;
    assign m1 = m + POS_W'(1);
    assign n1 = n + POS_W'(1);
    assign o1 = o + POS_W'(1);

    assign mask[0] = (r_ci == '0) || (r_ci == m1);
    assign mask[1] = (r_cj == '0) || (r_cj == n1);
    assign mask[2] = (r_ck == '0) || (r_ck == o1);
    assign bcount  = {1'b0, mask[0]} + {1'b0, mask[1]} + {1'b0, mask[2]};

    // step of the boundary scan over the whole padded box
    always_comb begin
        adv_state = S_B_SCAN;
        adv_sweep = r_sweep;
        adv_phase = r_phase;
        adv_ci    = r_ci;
        adv_cj    = r_cj;
        adv_ck    = r_ck;
        if (r_ck != o1) begin
            adv_ck = r_ck + POS_W'(1);
        end else begin
            adv_ck = '0;
            if (r_cj != n1) begin
                adv_cj = r_cj + POS_W'(1);
            end else begin
                adv_cj = '0;
                if (r_ci != m1) begin
                    adv_ci = r_ci + POS_W'(1);
                end else begin
                    adv_ci = '0;
                    if (r_phase != 2'd3) begin
                        adv_phase = r_phase + 2'd1;
                    end else if (r_sweep == 4'(SWEEPS - 1)) begin
                        adv_state = S_DONE;
                    end else begin
                        adv_state = S_U_START;
                        adv_sweep = r_sweep + 4'd1;
                        adv_ci    = POS_W'(1);
                        adv_cj    = POS_W'(1);
                        adv_ck    = POS_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        n_ci    = r_ci;
        n_cj    = r_cj;
        n_ck    = r_ck;
        n_t     = r_t;
        n_ax    = r_ax;
        n_phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_operation)
                        OP_SOLVE: begin
                            n_state = S_U_START;
                            n_sweep = '0;
                            n_ci    = POS_W'(1);
                            n_cj    = POS_W'(1);
                            n_ck    = POS_W'(1);
                        end
                        OP_READ: n_state = S_RD_WAIT;
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT: n_state = S_IDLE;
            S_U_START: begin
                n_state = S_U_RD;
                n_t     = NB_XM;
            end
            S_U_RD: begin
                if (r_t == NB_ZP) begin
                    n_state = S_U_SUM;
                end else begin
                    n_t = t_nbr'(r_t + 3'd1);
                end
            end
            S_U_SUM:  n_state = S_U_MUL;
            S_U_MUL:  n_state = S_U_TERM;
            S_U_TERM: n_state = S_U_NUM;
            S_U_NUM:  n_state = S_U_DGO;
            S_U_DGO:  n_state = S_U_DWAIT;
            S_U_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_U_WR;
                end
            end
            S_U_WR: begin
                n_state = S_U_START;
                if (r_ck != o) begin
                    n_ck = r_ck + POS_W'(1);
                end else begin
                    n_ck = POS_W'(1);
                    if (r_cj != n) begin
                        n_cj = r_cj + POS_W'(1);
                    end else begin
                        n_cj = POS_W'(1);
                        if (r_ci != m) begin
                            n_ci = r_ci + POS_W'(1);
                        end else begin
                            n_ci    = '0;
                            n_cj    = '0;
                            n_ck    = '0;
                            n_phase = 2'd1;
                            n_state = S_B_SCAN;
                        end
                    end
                end
            end
            S_B_SCAN: begin
                if (bcount == r_phase) begin
                    n_state = S_B_RD;
                    n_ax    = AX_X;
                end else begin
                    n_state = adv_state;
                    n_sweep = adv_sweep;
                    n_phase = adv_phase;
                    n_ci    = adv_ci;
                    n_cj    = adv_cj;
                    n_ck    = adv_ck;
                end
            end
            S_B_RD: begin
                if (r_ax == AX_Z) begin
                    n_state = S_B_SUM;
                end else begin
                    n_ax = t_axis'(r_ax + 2'd1);
                end
            end
            S_B_SUM: n_state = S_B_CALC;
            S_B_CALC, S_B_WR: begin
                if (r_state == S_B_CALC && r_phase == 2'd3) begin
                    n_state = S_B_DWAIT;
                end else begin
                    n_state = adv_state;
                    n_sweep = adv_sweep;
                    n_phase = adv_phase;
                    n_ci    = adv_ci;
                    n_cj    = adv_cj;
                    n_ck    = adv_ck;
                end
            end
            S_B_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_B_WR;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.wsel = WS_DIV;
        o_cmd.mask = mask;
        o_cmd.cx   = r_ci;
        o_cmd.cy   = r_cj;
        o_cmd.cz   = r_ck;
        case (r_state)
            S_IDLE: begin
                o_cmd.host_wr  = i_start && (i_operation == OP_WRITE);
                o_cmd.host_rd  = i_start && (i_operation == OP_READ);
                o_cmd.flag_clr = i_start && (i_operation == OP_SOLVE);
            end
            S_RD_WAIT: o_cmd.out_read = 1'b1;
            S_U_START: begin
                o_cmd.acc_clr = 1'b1;
                o_cmd.rd_src  = 1'b1;
            end
            S_U_RD: begin
                o_cmd.rd_sol = 1'b1;
                case (r_t)
                    NB_XM:   o_cmd.cx = r_ci - POS_W'(1);
                    NB_XP:   o_cmd.cx = r_ci + POS_W'(1);
                    NB_YM:   o_cmd.cy = r_cj - POS_W'(1);
                    NB_YP:   o_cmd.cy = r_cj + POS_W'(1);
                    NB_ZM:   o_cmd.cz = r_ck - POS_W'(1);
                    default: o_cmd.cz = r_ck + POS_W'(1);
                endcase
            end
            S_U_MUL:  o_cmd.mul = 1'b1;
            S_U_TERM: o_cmd.term = 1'b1;
            S_U_NUM:  o_cmd.num = 1'b1;
            S_U_DGO:  o_cmd.div_upd = 1'b1;
            S_U_WR:   o_cmd.wr = 1'b1;
            S_B_SCAN: o_cmd.acc_clr = 1'b1;
            S_B_RD: begin
                // each boundary axis contributes the cell one step toward the interior
                case (r_ax)
                    AX_X: begin
                        o_cmd.rd_sol = mask[0];
                        o_cmd.cx     = (r_ci == '0) ? POS_W'(1) : m;
                    end
                    AX_Y: begin
                        o_cmd.rd_sol = mask[1];
                        o_cmd.cy     = (r_cj == '0) ? POS_W'(1) : n;
                    end
                    default: begin
                        o_cmd.rd_sol = mask[2];
                        o_cmd.cz     = (r_ck == '0) ? POS_W'(1) : o;
                    end
                endcase
            end
            S_B_CALC: begin
                if (r_phase == 2'd3) begin
                    o_cmd.div_corner = 1'b1;
                end else begin
                    o_cmd.wr   = 1'b1;
                    o_cmd.wsel = (r_phase == 2'd1) ? WS_FACE : WS_EDGE;
                end
            end
            S_B_WR: o_cmd.wr = 1'b1;
            S_DONE: o_cmd.out_solve = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sweep <= '0;
            r_ci    <= '0;
            r_cj    <= '0;
            r_ck    <= '0;
            r_t     <= NB_XM;
            r_ax    <= AX_X;
            r_phase <= 2'd1;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_ci    <= n_ci;
            r_cj    <= n_cj;
            r_ck    <= n_ck;
            r_t     <= n_t;
            r_ax    <= n_ax;
            r_phase <= n_phase;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/grid_relaxation_solver_core.sv */
// Gauss-Seidel relaxation over a padded 3D grid of saturating Q16.16 cells. A cell write is
// taken while busy stays low, so writes stream one per clock. A read holds busy while in
// S_RD_WAIT and its result strobe is registered from that state. A solve holds busy for its
// ten sweeps: each interior cell reads its six neighbours, forms the gain product and the
// numerator, and waits on the serial divider behind the update; each sweep then scans the
// padded box three times (faces, edges, corners), and the corner cells also wait on the
// divider, while face and edge cells are written straight from their neighbour sums. Results
// appear on o_result_valid for exactly one cycle and cannot be stalled. The grid memories have
// no reset; a cell must be written before a solve or read depends on it.
module grid_relaxation_solver_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_operation,
    input  logic [grs_pkg::POS_W-1:0]  i_pos_i,
    input  logic [grs_pkg::POS_W-1:0]  i_pos_j,
    input  logic [grs_pkg::POS_W-1:0]  i_pos_k,
    input  logic signed [31:0]         i_source_value,
    input  logic signed [31:0]         i_guess_value,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [grs_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [30:0]                i_cfg_data,
    output logic                       o_result_valid,
    output logic                       o_result_kind,
    output logic signed [31:0]         o_cell_value,
    output logic                       o_saturated
);
    import grs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    grs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    grs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_pos_i        (i_pos_i),
        .i_pos_j        (i_pos_j),
        .i_pos_k        (i_pos_k),
        .i_source_value (i_source_value),
        .i_guess_value  (i_guess_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_cell_value   (o_cell_value),
        .o_saturated    (o_saturated)
    );

endmodule

/* sim/grid_relaxation_solver_checker.sv */
module grid_relaxation_solver_checker
    import grs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [1:0]          i_operation,
    input  logic [POS_W-1:0]    i_pos_i,
    input  logic [POS_W-1:0]    i_pos_j,
    input  logic [POS_W-1:0]    i_pos_k,
    input  logic [31:0]         i_source_value,
    input  logic [31:0]         i_guess_value,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [30:0]         i_cfg_data,
    input  logic                o_result_valid,
    input  logic                o_result_kind,
    input  logic [31:0]         o_cell_value,
    input  logic                o_saturated,
    output int                  o_failures,
    output int                  o_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint V_HI = 64'sd2147483647;
    localparam longint V_LO = -64'sd2147483648;

    typedef struct {
        bit        kind;
        bit [31:0] value;
        bit        sat;
    } t_cell_result;

    t_cell_result due_results[$];
    longint       sol_cells[CELLS];
    longint       src_cells[CELLS];
    bit           sat_seen;
    bit [4:0]     sz_x, sz_y, sz_z;
    bit [1:0]     bmode;
    bit [30:0]    gain, divisor;

    function automatic int cix(int i, int j, int k);
        return i + SIDE * (j + SIDE * k);
    endfunction

    function automatic bit [63:0] mag_of(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clip(bit neg, bit [63:0] m, bit flag);
        if (!neg) begin
            if (m > 64'd2147483647) begin
                if (flag) sat_seen = 1'b1;
                return V_HI;
            end
            return longint'(m);
        end
        if (m > 64'd2147483648) begin
            if (flag) sat_seen = 1'b1;
            return V_LO;
        end
        return -longint'(m);
    endfunction

    function automatic longint avg_round(longint s, bit [63:0] d);
        bit [63:0] q;
        q = (mag_of(s) + d / 2) / d;
        return s < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic int eff_size(bit [4:0] s);
        if (s == 0) return 1;
        return s > MAX_SIDE ? MAX_SIDE : int'(s);
    endfunction

    function automatic longint relax_cell(int i, int j, int k);
        longint    s, term, num;
        bit [63:0] ms, p0, p1, tm, d, a, q;
        s = sol_cells[cix(i-1, j, k)] + sol_cells[cix(i+1, j, k)]
          + sol_cells[cix(i, j-1, k)] + sol_cells[cix(i, j+1, k)]
          + sol_cells[cix(i, j, k-1)] + sol_cells[cix(i, j, k+1)];
        ms = mag_of(s);
        p0 = 64'(gain) * (ms & 64'hFFFF_FFFF);
        p1 = 64'(gain) * (ms >> 32);
        tm = (p1 < (64'd1 << 47)) ? (p1 << 16) + ((p0 + 64'h8000) >> 16) : (64'd1 << 63);
        term = clip(s < 0, tm, 1'b1);
        num = src_cells[cix(i, j, k)] + term;
        d = divisor < 31'd65536 ? 64'd65536 : 64'(divisor);
        a = mag_of(num);
        q = (a / d) * 64'd65536 + (((a % d) * 64'd65536 + d / 2) / d);
        return clip(num < 0, q, 1'b1);
    endfunction

    function automatic longint face_val(longint v, bit neg);
        return neg ? clip(v > 0, mag_of(v), 1'b1) : v;
    endfunction

    function automatic void fix_boundary(int m, int n, int o);
        int ci, cj, ck, ni, nj, nk, cj2, nj2;
        for (int a = 1; a <= n; a++) for (int b = 1; b <= o; b++) begin
            sol_cells[cix(0, a, b)]   = face_val(sol_cells[cix(1, a, b)], bmode == BMODE_NEG_X);
            sol_cells[cix(m+1, a, b)] = face_val(sol_cells[cix(m, a, b)], bmode == BMODE_NEG_X);
        end
        for (int a = 1; a <= m; a++) for (int b = 1; b <= o; b++) begin
            sol_cells[cix(a, 0, b)]   = face_val(sol_cells[cix(a, 1, b)], bmode == BMODE_NEG_Y);
            sol_cells[cix(a, n+1, b)] = face_val(sol_cells[cix(a, n, b)], bmode == BMODE_NEG_Y);
        end
        for (int a = 1; a <= m; a++) for (int b = 1; b <= n; b++) begin
            sol_cells[cix(a, b, 0)]   = face_val(sol_cells[cix(a, b, 1)], bmode == BMODE_NEG_Z);
            sol_cells[cix(a, b, o+1)] = face_val(sol_cells[cix(a, b, o)], bmode == BMODE_NEG_Z);
        end
        for (int s = 0; s < 4; s++) begin
            cj  = s[0] ? n + 1 : 0;  nj  = s[0] ? n : 1;
            ck  = s[1] ? o + 1 : 0;  nk  = s[1] ? o : 1;
            ci  = s[0] ? m + 1 : 0;  ni  = s[0] ? m : 1;
            cj2 = s[1] ? n + 1 : 0;  nj2 = s[1] ? n : 1;
            for (int a = 1; a <= m; a++)
                sol_cells[cix(a, cj, ck)] = avg_round(sol_cells[cix(a, nj, ck)]
                                                      + sol_cells[cix(a, cj, nk)], 2);
            for (int a = 1; a <= n; a++)
                sol_cells[cix(ci, a, ck)] = avg_round(sol_cells[cix(ni, a, ck)]
                                                      + sol_cells[cix(ci, a, nk)], 2);
            for (int a = 1; a <= o; a++)
                sol_cells[cix(ci, cj2, a)] = avg_round(sol_cells[cix(ni, cj2, a)]
                                                       + sol_cells[cix(ci, nj2, a)], 2);
        end
        for (int s = 0; s < 8; s++) begin
            ci = s[0] ? m + 1 : 0;  ni = s[0] ? m : 1;
            cj = s[1] ? n + 1 : 0;  nj = s[1] ? n : 1;
            ck = s[2] ? o + 1 : 0;  nk = s[2] ? o : 1;
            sol_cells[cix(ci, cj, ck)] = avg_round(sol_cells[cix(ni, cj, ck)]
                + sol_cells[cix(ci, nj, ck)] + sol_cells[cix(ci, cj, nk)], 3);
        end
    endfunction

    function automatic void run_sweeps();
        int m, n, o;
        m = eff_size(sz_x);
        n = eff_size(sz_y);
        o = eff_size(sz_z);
        sat_seen = 1'b0;
        for (int l = 0; l < SWEEPS; l++) begin
            for (int i = 1; i <= m; i++) for (int j = 1; j <= n; j++)
                for (int k = 1; k <= o; k++)
                    sol_cells[cix(i, j, k)] = relax_cell(i, j, k);
            fix_boundary(m, n, o);
        end
    endfunction

    function automatic void take_item();
        t_cell_result r;
        bit           in_grid;
        in_grid = i_pos_i <= MAX_SIDE + 1 && i_pos_j <= MAX_SIDE + 1 && i_pos_k <= MAX_SIDE + 1;
        case (i_operation)
            OP_WRITE: begin
                if (in_grid) begin
                    src_cells[cix(i_pos_i, i_pos_j, i_pos_k)] = longint'($signed(i_source_value));
                    sol_cells[cix(i_pos_i, i_pos_j, i_pos_k)] = longint'($signed(i_guess_value));
                end
            end
            OP_SOLVE: begin
                run_sweeps();
                r.kind  = 1'b0;
                r.value = '0;
                r.sat   = sat_seen;
                due_results.push_back(r);
            end
            OP_READ: begin
                r.kind  = 1'b1;
                r.value = in_grid ? 32'(sol_cells[cix(i_pos_i, i_pos_j, i_pos_k)]) : '0;
                r.sat   = sat_seen;
                due_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_cell_result e;
        if (!i_rst_n) begin
            due_results.delete();
            sat_seen = 1'b0;
            sz_x = 5'd16;
            sz_y = 5'd16;
            sz_z = 5'd16;
            bmode = 2'd0;
            gain = 31'd65536;
            divisor = 31'd393216;
            o_failures <= 0;
        end else begin
            if (o_result_valid) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_failures <= o_failures + 1;
                end else begin
                    e = due_results.pop_front();
                    if (o_result_kind !== e.kind) begin
                        $error("result_kind: expected %0d, got %0d", e.kind, o_result_kind);
                        o_failures <= o_failures + 1;
                    end
                    if (o_cell_value !== e.value) begin
                        $error("cell_value: expected %h, got %h", e.value, o_cell_value);
                        o_failures <= o_failures + 1;
                    end
                    if (o_saturated !== e.sat) begin
                        $error("saturated: expected %0d, got %0d", e.sat, o_saturated);
                        o_failures <= o_failures + 1;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SIZE_X:  sz_x = i_cfg_data[4:0];
                    CFG_SIZE_Y:  sz_y = i_cfg_data[4:0];
                    CFG_SIZE_Z:  sz_z = i_cfg_data[4:0];
                    CFG_BMODE:   bmode = i_cfg_data[1:0];
                    CFG_GAIN:    gain = i_cfg_data;
                    CFG_DIVISOR: divisor = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) take_item();
        end
        o_due <= due_results.size();
    end

endmodule

/* sim/grid_relaxation_solver_core_test.sv */
module grid_relaxation_solver_core_test;
    import grs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         ITEM_GOAL = 1850;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_operation = '0;
    logic [POS_W-1:0]   i_pos_i = '0, i_pos_j = '0, i_pos_k = '0;
    logic signed [31:0] i_source_value = '0, i_guess_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IW-1:0]  i_cfg_index = '0;
    logic [30:0]        i_cfg_data = '0;
    logic               o_result_valid, o_result_kind, o_saturated;
    logic signed [31:0] o_cell_value;
    int                 failures, results_due;

    bit                 filled[CELLS];
    int                 n_items;
    int                 ext_x, ext_y, ext_z;

    always #4 i_clk = ~i_clk;

    grid_relaxation_solver_core dut (.*);

    grid_relaxation_solver_checker checker_u (
        .i_clk, .i_rst_n, .start, .busy, .i_operation, .i_pos_i, .i_pos_j, .i_pos_k,
        .i_source_value, .i_guess_value, .i_cfg_valid, .o_cfg_ready, .i_cfg_index,
        .i_cfg_data, .o_result_valid, .o_result_kind, .o_cell_value, .o_saturated,
        .o_failures(failures), .o_due(results_due)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        endcase
    endfunction

    function automatic int clamp_side(int s);
        if (s == 0) return 1;
        return s > MAX_SIDE ? MAX_SIDE : s;
    endfunction

    // called just after a falling edge; returns just after a later falling edge, once the item is taken
    task automatic send_item(logic [1:0] op, int pi, int pj, int pk,
                             logic [31:0] src, logic [31:0] guess);
        int g;
        g = gap_len();
        if (g > 0) begin
            start = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_operation = op;
        i_pos_i = POS_W'(pi);
        i_pos_j = POS_W'(pj);
        i_pos_k = POS_W'(pk);
        i_source_value = src;
        i_guess_value = guess;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        if (op == OP_WRITE && pi <= MAX_SIDE + 1 && pj <= MAX_SIDE + 1 && pk <= MAX_SIDE + 1)
            filled[pi + SIDE * (pj + SIDE * pk)] = 1'b1;
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic write_cell(int pi, int pj, int pk);
        send_item(OP_WRITE, pi, pj, pk, pick_value(), pick_value());
    endtask

    task automatic read_cell(int pi, int pj, int pk);
        send_item(OP_READ, pi, pj, pk, $urandom(), $urandom());
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (results_due != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [30:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(int sx, int sy, int sz, int bm, logic [30:0] g, logic [30:0] d);
        wait_idle();
        write_reg(CFG_SIZE_X, ($urandom() & 31'h7FFF_FFE0) | 31'(sx));
        write_reg(CFG_SIZE_Y, ($urandom() & 31'h7FFF_FFE0) | 31'(sy));
        write_reg(CFG_SIZE_Z, ($urandom() & 31'h7FFF_FFE0) | 31'(sz));
        write_reg(CFG_BMODE, ($urandom() & 31'h7FFF_FFFC) | 31'(bm));
        write_reg(CFG_GAIN, g);
        write_reg(CFG_DIVISOR, d);
        ext_x = clamp_side(sx);
        ext_y = clamp_side(sy);
        ext_z = clamp_side(sz);
    endtask

    task automatic read_somewhere();
        int pi, pj, pk;
        if ($urandom_range(0, 7) == 0) begin
            pi = $urandom_range(0, 31);
            pj = $urandom_range(0, 31);
            pk = $urandom_range(18, 31);
            case ($urandom_range(0, 2))
                0: read_cell(pk, pi, pj);
                1: read_cell(pi, pk, pj);
                default: read_cell(pi, pj, pk);
            endcase
        end else begin
            pi = $urandom_range(0, ext_x + 1);
            pj = $urandom_range(0, ext_y + 1);
            pk = $urandom_range(0, ext_z + 1);
            // the box may not be fully written yet when this is called from a noise item
            read_cell(pi, pj, pk);
        end
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 2))
            0: send_item(OP_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom(), $urandom());
            1: send_item(OP_WRITE, $urandom_range(18, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom(), $urandom());
            default: read_somewhere();
        endcase
    endtask

    task automatic fill_and_solve();
        for (int k = 0; k <= ext_z + 1; k++)
            for (int j = 0; j <= ext_y + 1; j++)
                for (int i = 0; i <= ext_x + 1; i++) begin
                    if (!filled[i + SIDE * (j + SIDE * k)] || $urandom_range(0, 7) == 0)
                        write_cell(i, j, k);
                    if ($urandom_range(0, 15) == 0) noise_item();
                end
        send_item(OP_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom(), $urandom());
        repeat ($urandom_range(4, 20)) read_somewhere();
        if ($urandom_range(0, 2) == 0) begin
            send_item(OP_SOLVE, 0, 0, 0, '0, '0);
            repeat ($urandom_range(2, 8)) read_somewhere();
        end
    endtask

    function automatic logic [30:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom());
            default: return 31'($urandom_range(0, 3 * 65536));
        endcase
    endfunction

    function automatic logic [30:0] pick_divisor();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'($urandom_range(1, 65535));
            2: return 31'h7FFF_FFFF;
            3: return 31'($urandom());
            default: return 31'($urandom_range(65536, 10 * 65536));
        endcase
    endfunction

    function automatic int pick_side();
        return $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 3);
    endfunction

    initial begin
        int sx, sy, sz, wide_axis, wide;
        n_items = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // zero sizes act as one, small divisor acts as one, huge gain
        set_regs(0, 0, 0, BMODE_NEG_X, 31'h7FFF_FFFF, '0);
        send_item(OP_WRITE, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_WRITE, 17, 17, 17, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_WRITE, 31, 0, 0, 32'h1234_5678, 32'h1234_5678);
        send_item(OP_WRITE, 0, 18, 0, '1, '1);
        send_item(OP_READ, 17, 17, 17, '0, '0);
        send_item(OP_READ, 0, 0, 0, '0, '0);
        send_item(OP_READ, 0, 0, 31, '0, '0);
        send_item(OP_UNUSED, 31, 31, 31, '1, '1);
        fill_and_solve();

        while (n_items < ITEM_GOAL) begin
            sx = pick_side();
            sy = pick_side();
            sz = pick_side();
            if ($urandom_range(0, 7) == 0) begin
                // one long axis at full or over-range size, the others minimal
                wide_axis = $urandom_range(0, 2);
                wide = $urandom_range(0, 1) ? MAX_SIDE : $urandom_range(MAX_SIDE + 1, 31);
                sx = wide_axis == 0 ? wide : $urandom_range(0, 1);
                sy = wide_axis == 1 ? wide : $urandom_range(0, 1);
                sz = wide_axis == 2 ? wide : $urandom_range(0, 1);
            end
            set_regs(sx, sy, sz, $urandom_range(0, 3), pick_gain(), pick_divisor());
            fill_and_solve();
        end

        start = 1'b0;
        while (results_due != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
